@@ src/wav_chunk_stream_parser_core_defines.svh @@
// Assertion macros shared by the WAV chunk stream parser RTL.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef WAV_CHUNK_STREAM_PARSER_CORE_DEFINES_SVH
`define WAV_CHUNK_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WCSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wcsp_pkg.sv @@
// Shared types and constants for the WAV chunk stream parser.
// Used by wcsp_step and wav_chunk_stream_parser_core; depends on nothing.
package wcsp_pkg;

  // Chunk tags as they appear in a little-endian shift of four file bytes.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_CUE  = 32'h2065_7563;
  localparam logic [31:0] TAG_SMPL = 32'h6C70_6D73;

  localparam logic [3:0]  FMT_WORDS      = 4'd4;
  localparam logic [3:0]  CUE_FIELDS     = 4'd6;
  localparam logic [3:0]  SMPL_FIELDS    = 4'd9;
  localparam logic [3:0]  SMPL_LOOP_CNT  = 4'd7;
  localparam logic [3:0]  LOOP_FIELDS    = 4'd6;
  localparam logic [15:0] PCM_CODE       = 16'd1;
  localparam logic [15:0] BITS_REQUIRED  = 16'd16;

  // Record kinds.
  localparam logic [2:0] KIND_FORMAT  = 3'd0;
  localparam logic [2:0] KIND_SAMPLE  = 3'd1;
  localparam logic [2:0] KIND_CUE     = 3'd2;
  localparam logic [2:0] KIND_SAMPLER = 3'd3;
  localparam logic [2:0] KIND_LOOP    = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // Error codes.
  localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM     = 3'd2;
  localparam logic [2:0] ERR_NOT_16BIT   = 3'd3;
  localparam logic [2:0] ERR_NO_CHANNELS = 3'd4;

  typedef enum logic [12:0] {
    PH_RIFF     = 13'b0_0000_0000_0001,
    PH_RSIZE    = 13'b0_0000_0000_0010,
    PH_WAVE     = 13'b0_0000_0000_0100,
    PH_CID      = 13'b0_0000_0000_1000,
    PH_CSIZE    = 13'b0_0000_0001_0000,
    PH_FMT      = 13'b0_0000_0010_0000,
    PH_DATA     = 13'b0_0000_0100_0000,
    PH_CUE_HDR  = 13'b0_0000_1000_0000,
    PH_CUE_PT   = 13'b0_0001_0000_0000,
    PH_SMPL_HDR = 13'b0_0010_0000_0000,
    PH_LOOP     = 13'b0_0100_0000_0000,
    PH_SKIP     = 13'b0_1000_0000_0000,
    PH_HALT     = 13'b1_0000_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  byte_in_word;
    logic [31:0] word_shift;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_bytes_left;
    logic [31:0] entry_count_left;
    logic [3:0]  field_counter;
    logic [15:0] channel_total;
    logic [15:0] channel_position;
    logic        data_seen;
  } parse_state_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         kind;
    logic [15:0]        index;
    logic [31:0]        value;
    logic signed [15:0] sample;
    logic [2:0]         err;
  } rec_t;

endpackage

@@ src/wav_chunk_stream_parser_core.sv @@
// Top level of the RIFF/WAVE chunk stream parser.
// Depends on wcsp_pkg, wcsp_step and wav_chunk_stream_parser_core_defines.svh.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_file_byte (one file byte per item)
//   out_     output     out_valid/out_stall out_record_kind, out_field_index,
//                                           out_field_value, out_sample_value,
//                                           out_error_code
//
// Each item waits in the input register until the parser steps on it; a record it
// yields is loaded into the output register at the edge that ends that step.
// One item is accepted per cycle, limited only by the output register.
// Reset (rst_n low, synchronous) returns the parser to waiting for the RIFF tag
// and empties both registers. When out_stall holds a record, the waiting item
// stays in the input register and in_stall rises; nothing else is lost.
`include "wav_chunk_stream_parser_core_defines.svh"

module wav_chunk_stream_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_file_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_record_kind,
  output logic [15:0]        out_field_index,
  output logic [31:0]        out_field_value,
  output logic signed [15:0] out_sample_value,
  output logic [2:0]         out_error_code
);

  // Input register: holds one accepted byte until the parser steps on it.
  logic       in_valid_r;
  logic       in_valid_nxt;
  logic [7:0] in_byte_r;

  // Parser state, advanced once per byte.
  wcsp_pkg::parse_state_t st_r;
  wcsp_pkg::parse_state_t st_nxt;
  wcsp_pkg::rec_t         rec;

  // Output register.
  logic           out_valid_r;
  logic           out_valid_nxt;
  wcsp_pkg::rec_t out_rec_r;

  logic step;
  logic in_take;

  // The parser steps whenever a byte is waiting and the output register
  // either is empty or is being emptied in this cycle.
  assign step     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  wcsp_step u_step (
    .st        (st_r),
    .file_byte (in_byte_r),
    .st_nxt    (st_nxt),
    .rec       (rec)
  );

  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_comb begin
    if (step) begin
      out_valid_nxt = rec.valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: wcsp_pkg::PH_RIFF, default: '0};
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) st_r <= st_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_file_byte;
    if (step && rec.valid) out_rec_r <= rec;
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = out_rec_r.kind;
  assign out_field_index  = out_rec_r.index;
  assign out_field_value  = out_rec_r.value;
  assign out_sample_value = out_rec_r.sample;
  assign out_error_code   = out_rec_r.err;

  // An error halts the parser for good.
  `WCSP_ASSERT_NEXT(a_halt_sticky, st_r.phase == wcsp_pkg::PH_HALT,
    st_r.phase == wcsp_pkg::PH_HALT, "parser left the halted state")
  // An error record is only ever presented once the parser has halted.
  `WCSP_ASSERT_NOW(a_err_halted,
    out_valid_r && out_rec_r.kind == wcsp_pkg::KIND_ERROR,
    st_r.phase == wcsp_pkg::PH_HALT, "error record without halted parser")
  // Samples come only from a data chunk that was entered.
  `WCSP_ASSERT_NOW(a_sample_data, out_valid_r && out_rec_r.kind == wcsp_pkg::KIND_SAMPLE,
    st_r.data_seen, "sample record before any data chunk")
  // Back-pressure on the input only while a byte is actually waiting.
  `WCSP_ASSERT_NOW(a_stall_holds, in_stall, in_valid_r && out_valid_r && out_stall,
    "input stalled without a blocked byte")

endmodule

@@ src/wcsp_step.sv @@
// Next-state and record logic for one file byte of the WAV parser.
// Purely combinational; depends on wcsp_pkg.
module wcsp_step (
  input  wcsp_pkg::parse_state_t st,
  input  logic [7:0]             file_byte,
  output wcsp_pkg::parse_state_t st_nxt,
  output wcsp_pkg::rec_t         rec
);

  logic [31:0] ws;
  logic        done;
  logic        bounded;
  logic [31:0] cbl_dec;
  logic [31:0] ecl_dec;
  logic [3:0]  fc_inc;
  logic [16:0] pos_inc;

  assign ws      = {file_byte, st.word_shift[31:8]};
  assign done    = (st.byte_in_word == 2'd3);
  assign cbl_dec = st.chunk_bytes_left - 32'd1;
  assign ecl_dec = st.entry_count_left - 32'd1;
  assign fc_inc  = st.field_counter + 4'd1;
  assign pos_inc = {1'b0, st.channel_position} + 17'd1;

  always_comb begin
    st_nxt  = st;
    rec     = '0;
    bounded = 1'b0;
    if (st.phase != wcsp_pkg::PH_HALT) begin
      st_nxt.word_shift   = ws;
      st_nxt.byte_in_word = st.byte_in_word + 2'd1;
      case (st.phase)
        wcsp_pkg::PH_RIFF: begin
          if (done) begin
            if (ws != wcsp_pkg::TAG_RIFF) begin
              st_nxt.phase = wcsp_pkg::PH_HALT;
              rec.valid    = 1'b1;
              rec.kind     = wcsp_pkg::KIND_ERROR;
              rec.err      = wcsp_pkg::ERR_NOT_RIFF;
            end else begin
              st_nxt.phase = wcsp_pkg::PH_RSIZE;
            end
          end
        end
        wcsp_pkg::PH_RSIZE: begin
          if (done) st_nxt.phase = wcsp_pkg::PH_WAVE;
        end
        wcsp_pkg::PH_WAVE: begin
          if (done) begin
            if (ws != wcsp_pkg::TAG_WAVE) begin
              st_nxt.phase = wcsp_pkg::PH_HALT;
              rec.valid    = 1'b1;
              rec.kind     = wcsp_pkg::KIND_ERROR;
              rec.err      = wcsp_pkg::ERR_NOT_WAVE;
            end else begin
              st_nxt.phase = wcsp_pkg::PH_CID;
            end
          end
        end
        wcsp_pkg::PH_CID: begin
          if (done) begin
            st_nxt.chunk_tag = ws;
            st_nxt.phase     = wcsp_pkg::PH_CSIZE;
          end
        end
        wcsp_pkg::PH_CSIZE: begin
          if (done) begin
            st_nxt.chunk_bytes_left = ws;
            st_nxt.byte_in_word     = 2'd0;
            st_nxt.field_counter    = 4'd0;
            if (st.chunk_tag == wcsp_pkg::TAG_FMT) begin
              st_nxt.phase = wcsp_pkg::PH_FMT;
            end else if (st.chunk_tag == wcsp_pkg::TAG_DATA) begin
              if (st.data_seen) begin
                st_nxt.phase = wcsp_pkg::PH_SKIP;
              end else begin
                st_nxt.data_seen        = 1'b1;
                st_nxt.channel_position = 16'd0;
                st_nxt.phase            = wcsp_pkg::PH_DATA;
              end
            end else if (st.chunk_tag == wcsp_pkg::TAG_CUE) begin
              st_nxt.phase = wcsp_pkg::PH_CUE_HDR;
            end else if (st.chunk_tag == wcsp_pkg::TAG_SMPL) begin
              st_nxt.phase = wcsp_pkg::PH_SMPL_HDR;
            end else begin
              st_nxt.phase = wcsp_pkg::PH_SKIP;
            end
            if (ws == 32'd0) st_nxt.phase = wcsp_pkg::PH_CID;
            // A data chunk with no channel count known is fatal.
            if (st.chunk_tag == wcsp_pkg::TAG_DATA && st.channel_total == 16'd0) begin
              st_nxt.phase = wcsp_pkg::PH_HALT;
              rec.valid    = 1'b1;
              rec.kind     = wcsp_pkg::KIND_ERROR;
              rec.err      = wcsp_pkg::ERR_NO_CHANNELS;
            end
          end
        end
        wcsp_pkg::PH_FMT: begin
          bounded                 = 1'b1;
          st_nxt.chunk_bytes_left = cbl_dec;
          if (done) begin
            st_nxt.field_counter = fc_inc;
            if (fc_inc >= wcsp_pkg::FMT_WORDS) st_nxt.phase = wcsp_pkg::PH_SKIP;
            if (st.field_counter == 4'd0) begin
              if (ws[15:0] != wcsp_pkg::PCM_CODE) begin
                st_nxt.phase = wcsp_pkg::PH_HALT;
                rec.valid    = 1'b1;
                rec.kind     = wcsp_pkg::KIND_ERROR;
                rec.err      = wcsp_pkg::ERR_NOT_PCM;
              end else begin
                st_nxt.channel_total = ws[31:16];
                rec.valid = 1'b1;
                rec.kind  = wcsp_pkg::KIND_FORMAT;
                rec.index = 16'd0;
                rec.value = {16'd0, ws[31:16]};
              end
            end else if (st.field_counter == 4'd1) begin
              rec.valid = 1'b1;
              rec.kind  = wcsp_pkg::KIND_FORMAT;
              rec.index = 16'd1;
              rec.value = ws;
            end else if (st.field_counter == 4'd3) begin
              if (ws[31:16] != wcsp_pkg::BITS_REQUIRED) begin
                st_nxt.phase = wcsp_pkg::PH_HALT;
                rec.valid    = 1'b1;
                rec.kind     = wcsp_pkg::KIND_ERROR;
                rec.err      = wcsp_pkg::ERR_NOT_16BIT;
              end
            end
          end
        end
        wcsp_pkg::PH_DATA: begin
          bounded                 = 1'b1;
          st_nxt.chunk_bytes_left = cbl_dec;
          if (st.byte_in_word[0]) begin
            rec.valid  = 1'b1;
            rec.kind   = wcsp_pkg::KIND_SAMPLE;
            rec.index  = st.channel_position;
            rec.sample = ws[31:16];
            if (pos_inc >= {1'b0, st.channel_total}) begin
              st_nxt.channel_position = 16'd0;
            end else begin
              st_nxt.channel_position = pos_inc[15:0];
            end
          end
        end
        wcsp_pkg::PH_CUE_HDR: begin
          bounded                 = 1'b1;
          st_nxt.chunk_bytes_left = cbl_dec;
          if (done) begin
            st_nxt.entry_count_left = ws;
            st_nxt.field_counter    = 4'd0;
            st_nxt.phase = (ws == 32'd0) ? wcsp_pkg::PH_SKIP : wcsp_pkg::PH_CUE_PT;
            rec.valid = 1'b1;
            rec.kind  = wcsp_pkg::KIND_CUE;
            rec.index = 16'd0;
            rec.value = ws;
          end
        end
        wcsp_pkg::PH_CUE_PT: begin
          bounded                 = 1'b1;
          st_nxt.chunk_bytes_left = cbl_dec;
          if (done) begin
            rec.valid = 1'b1;
            rec.kind  = wcsp_pkg::KIND_CUE;
            rec.index = {12'd0, fc_inc};
            rec.value = ws;
            st_nxt.field_counter = fc_inc;
            if (fc_inc >= wcsp_pkg::CUE_FIELDS) begin
              st_nxt.field_counter    = 4'd0;
              st_nxt.entry_count_left = ecl_dec;
              if (ecl_dec == 32'd0) st_nxt.phase = wcsp_pkg::PH_SKIP;
            end
          end
        end
        wcsp_pkg::PH_SMPL_HDR: begin
          bounded                 = 1'b1;
          st_nxt.chunk_bytes_left = cbl_dec;
          if (done) begin
            rec.valid = 1'b1;
            rec.kind  = wcsp_pkg::KIND_SAMPLER;
            rec.index = {12'd0, st.field_counter};
            rec.value = ws;
            if (st.field_counter == wcsp_pkg::SMPL_LOOP_CNT) st_nxt.entry_count_left = ws;
            st_nxt.field_counter = fc_inc;
            if (fc_inc >= wcsp_pkg::SMPL_FIELDS) begin
              // The loop count was captured on the previous word.
              st_nxt.field_counter = 4'd0;
              st_nxt.phase = (st.entry_count_left == 32'd0) ? wcsp_pkg::PH_SKIP
                                                             : wcsp_pkg::PH_LOOP;
            end
          end
        end
        wcsp_pkg::PH_LOOP: begin
          bounded                 = 1'b1;
          st_nxt.chunk_bytes_left = cbl_dec;
          if (done) begin
            rec.valid = 1'b1;
            rec.kind  = wcsp_pkg::KIND_LOOP;
            rec.index = {12'd0, st.field_counter};
            rec.value = ws;
            st_nxt.field_counter = fc_inc;
            if (fc_inc >= wcsp_pkg::LOOP_FIELDS) begin
              st_nxt.field_counter    = 4'd0;
              st_nxt.entry_count_left = ecl_dec;
              if (ecl_dec == 32'd0) st_nxt.phase = wcsp_pkg::PH_SKIP;
            end
          end
        end
        wcsp_pkg::PH_SKIP: begin
          bounded                 = 1'b1;
          st_nxt.chunk_bytes_left = cbl_dec;
        end
        default: begin
          st_nxt = st;
        end
      endcase
      // The end of a chunk wins over any structure still in progress.
      if (bounded && cbl_dec == 32'd0 && st_nxt.phase != wcsp_pkg::PH_HALT) begin
        st_nxt.phase         = wcsp_pkg::PH_CID;
        st_nxt.byte_in_word  = 2'd0;
        st_nxt.field_counter = 4'd0;
      end
    end
  end

endmodule

@@ verif/wav_chunk_stream_parser_core_tb.sv @@
// Self-checking testbench for wav_chunk_stream_parser_core: feeds a RIFF/WAVE byte stream
// and checks every record against a cycle-free model of the chunk parser.
// Depends on wcsp_pkg and the parser RTL only.
module wav_chunk_stream_parser_core_tb;

  // The receiver stalls for a long stretch once this many records have been taken.
  localparam int HOLD_AT   = 12;
  localparam int LONG_HOLD = 120;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] index;
    logic [31:0] value;
    logic [15:0] sample;
    logic [2:0]  err;
  } wav_rec_t;

  // One planned input item; drain makes the sender wait until every record is back.
  typedef struct {
    logic [7:0] data;
    bit         drain;
  } plan_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_file_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_record_kind;
  logic [15:0]        out_field_index;
  logic [31:0]        out_field_value;
  logic signed [15:0] out_sample_value;
  logic [2:0]         out_error_code;

  plan_item_t  byte_plan[$];
  logic [31:0] chunk_words[$];
  wav_rec_t    records_due[$];
  int          records_seen = 0;
  int          failures = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;

  // Parser state as the model keeps it. Reset happens once, so the initial
  // values stand for the state right after reset.
  wcsp_pkg::phase_t ph = wcsp_pkg::PH_RIFF;
  logic [1:0]  byte_pos = 2'd0;
  logic [31:0] shift_word = 32'd0;
  logic [31:0] cur_tag = 32'd0;
  logic [31:0] bytes_left = 32'd0;
  logic [31:0] entries_left = 32'd0;
  logic [3:0]  fld = 4'd0;
  logic [15:0] chan_count = 16'd0;
  logic [15:0] chan_pos = 16'd0;
  logic        data_done = 1'b0;
  logic        halted = 1'b0;

  wav_chunk_stream_parser_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_file_byte     (in_file_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_kind  (out_record_kind),
    .out_field_index  (out_field_index),
    .out_field_value  (out_field_value),
    .out_sample_value (out_sample_value),
    .out_error_code   (out_error_code)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // A generous bound on the whole run; a correct run ends long before it.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Queue helpers.
  // ---------------------------------------------------------------------------

  task automatic add_plan(input logic [7:0] d, input bit drain);
    plan_item_t it;
    it.data  = d;
    it.drain = drain;
    byte_plan.insert(byte_plan.size(), it);
  endtask

  task automatic add_word(input logic [31:0] w);
    chunk_words.insert(chunk_words.size(), w);
  endtask

  // ---------------------------------------------------------------------------
  // Model of the parser: one call per accepted item.
  // ---------------------------------------------------------------------------

  task automatic post(input logic [2:0] kind, input logic [15:0] idx,
                      input logic [31:0] val, input logic [15:0] samp,
                      input logic [2:0] err);
    wav_rec_t r;
    r = '{kind, idx, val, samp, err};
    records_due.insert(records_due.size(), r);
  endtask

  // Any error emits one record and freezes the parser for good.
  task automatic post_error(input logic [2:0] code);
    halted = 1'b1;
    ph = wcsp_pkg::PH_HALT;
    post(wcsp_pkg::KIND_ERROR, 16'd0, 32'd0, 16'd0, code);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [1:0] prev;
    logic       done;
    if (halted) return;
    prev = byte_pos;
    shift_word = {b, shift_word[31:8]};
    done = (prev == 2'd3);
    byte_pos = prev + 2'd1;

    // The file header and the tag/size pair of each chunk are not bounded by
    // any chunk size.
    case (ph)
      wcsp_pkg::PH_RIFF: begin
        if (done) begin
          if (shift_word != wcsp_pkg::TAG_RIFF) post_error(wcsp_pkg::ERR_NOT_RIFF);
          else ph = wcsp_pkg::PH_RSIZE;
        end
        return;
      end
      wcsp_pkg::PH_RSIZE: begin
        if (done) ph = wcsp_pkg::PH_WAVE;
        return;
      end
      wcsp_pkg::PH_WAVE: begin
        if (done) begin
          if (shift_word != wcsp_pkg::TAG_WAVE) post_error(wcsp_pkg::ERR_NOT_WAVE);
          else ph = wcsp_pkg::PH_CID;
        end
        return;
      end
      wcsp_pkg::PH_CID: begin
        if (done) begin
          cur_tag = shift_word;
          ph = wcsp_pkg::PH_CSIZE;
        end
        return;
      end
      wcsp_pkg::PH_CSIZE: begin
        if (!done) return;
        bytes_left = shift_word;
        byte_pos = 2'd0;
        fld = 4'd0;
        if (cur_tag == wcsp_pkg::TAG_FMT) begin
          ph = wcsp_pkg::PH_FMT;
        end else if (cur_tag == wcsp_pkg::TAG_DATA) begin
          // A data chunk with no channel count known is fatal; only the first
          // data chunk carries samples.
          if (chan_count == 16'd0) begin
            post_error(wcsp_pkg::ERR_NO_CHANNELS);
            return;
          end
          if (data_done) begin
            ph = wcsp_pkg::PH_SKIP;
          end else begin
            data_done = 1'b1;
            chan_pos = 16'd0;
            ph = wcsp_pkg::PH_DATA;
          end
        end else if (cur_tag == wcsp_pkg::TAG_CUE) begin
          ph = wcsp_pkg::PH_CUE_HDR;
        end else if (cur_tag == wcsp_pkg::TAG_SMPL) begin
          ph = wcsp_pkg::PH_SMPL_HDR;
        end else begin
          ph = wcsp_pkg::PH_SKIP;
        end
        if (bytes_left == 32'd0) ph = wcsp_pkg::PH_CID;
        return;
      end
      default: ;
    endcase

    // From here on the byte belongs to the body of a chunk.
    bytes_left = bytes_left - 32'd1;

    case (ph)
      wcsp_pkg::PH_FMT: begin
        if (done) begin
          if (fld == 4'd0) begin
            if (shift_word[15:0] != wcsp_pkg::PCM_CODE) begin
              post_error(wcsp_pkg::ERR_NOT_PCM);
              return;
            end
            chan_count = shift_word[31:16];
            post(wcsp_pkg::KIND_FORMAT, 16'd0, {16'd0, chan_count}, 16'd0, 3'd0);
          end else if (fld == 4'd1) begin
            post(wcsp_pkg::KIND_FORMAT, 16'd1, shift_word, 16'd0, 3'd0);
          end else if (fld == 4'd3) begin
            if (shift_word[31:16] != wcsp_pkg::BITS_REQUIRED) begin
              post_error(wcsp_pkg::ERR_NOT_16BIT);
              return;
            end
          end
          fld = fld + 4'd1;
          if (fld >= wcsp_pkg::FMT_WORDS) ph = wcsp_pkg::PH_SKIP;
        end
      end
      wcsp_pkg::PH_DATA: begin
        if (prev[0]) begin
          post(wcsp_pkg::KIND_SAMPLE, chan_pos, 32'd0, shift_word[31:16], 3'd0);
          chan_pos = chan_pos + 16'd1;
          if (chan_pos >= chan_count) chan_pos = 16'd0;
        end
      end
      wcsp_pkg::PH_CUE_HDR: begin
        if (done) begin
          entries_left = shift_word;
          post(wcsp_pkg::KIND_CUE, 16'd0, shift_word, 16'd0, 3'd0);
          fld = 4'd0;
          ph = (entries_left == 32'd0) ? wcsp_pkg::PH_SKIP : wcsp_pkg::PH_CUE_PT;
        end
      end
      wcsp_pkg::PH_CUE_PT: begin
        if (done) begin
          post(wcsp_pkg::KIND_CUE, {12'd0, fld} + 16'd1, shift_word, 16'd0, 3'd0);
          fld = fld + 4'd1;
          if (fld >= wcsp_pkg::CUE_FIELDS) begin
            fld = 4'd0;
            entries_left = entries_left - 32'd1;
            if (entries_left == 32'd0) ph = wcsp_pkg::PH_SKIP;
          end
        end
      end
      wcsp_pkg::PH_SMPL_HDR: begin
        if (done) begin
          post(wcsp_pkg::KIND_SAMPLER, {12'd0, fld}, shift_word, 16'd0, 3'd0);
          if (fld == wcsp_pkg::SMPL_LOOP_CNT) entries_left = shift_word;
          fld = fld + 4'd1;
          if (fld >= wcsp_pkg::SMPL_FIELDS) begin
            fld = 4'd0;
            ph = (entries_left == 32'd0) ? wcsp_pkg::PH_SKIP : wcsp_pkg::PH_LOOP;
          end
        end
      end
      wcsp_pkg::PH_LOOP: begin
        if (done) begin
          post(wcsp_pkg::KIND_LOOP, {12'd0, fld}, shift_word, 16'd0, 3'd0);
          fld = fld + 4'd1;
          if (fld >= wcsp_pkg::LOOP_FIELDS) begin
            fld = 4'd0;
            entries_left = entries_left - 32'd1;
            if (entries_left == 32'd0) ph = wcsp_pkg::PH_SKIP;
          end
        end
      end
      default: ;
    endcase

    // The chunk size wins over any structure: a partial word is dropped.
    if (bytes_left == 32'd0) begin
      ph = wcsp_pkg::PH_CID;
      byte_pos = 2'd0;
      fld = 4'd0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Building the file.
  // ---------------------------------------------------------------------------

  // Mostly random words, with the all-zero, all-one and signed-extreme patterns
  // showing up often.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_8000;
      3: return 32'h8000_7FFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic plan_word(input logic [31:0] w, input bit drain);
    add_plan(w[7:0], drain);
    add_plan(w[15:8], 1'b0);
    add_plan(w[23:16], 1'b0);
    add_plan(w[31:24], 1'b0);
  endtask

  // Emits a chunk header and exactly size body bytes: the prepared words first,
  // random filler after them.
  task automatic plan_chunk(input logic [31:0] tag, input logic [31:0] size, input bit drain);
    logic [7:0] b;
    plan_word(tag, drain);
    plan_word(size, 1'b0);
    for (int unsigned i = 0; i < size; i++) begin
      if (i / 4 < chunk_words.size()) b = 8'(chunk_words[i / 4] >> (8 * (i % 4)));
      else b = 8'($urandom);
      add_plan(b, 1'b0);
    end
  endtask

  // Declared size: usually exact, sometimes cut short mid-structure, sometimes
  // with extra bytes past the structure.
  function automatic logic [31:0] struct_size();
    int unsigned exact;
    exact = chunk_words.size() * 4;
    case ($urandom_range(0, 3))
      0: return (exact > 0) ? $urandom_range(0, exact - 1) : 0;
      1: return exact + $urandom_range(1, 6);
      default: return exact;
    endcase
  endfunction

  task automatic fill_fmt(input logic [15:0] code, input logic [15:0] chans,
                          input logic [31:0] rate, input logic [15:0] bits);
    chunk_words.delete();
    add_word({chans, code});
    add_word(rate);
    add_word(rate * chans * 2);
    add_word({bits, chans * 16'd2});
  endtask

  task automatic fill_cue(input int unsigned points);
    chunk_words.delete();
    add_word(points);
    repeat (6 * points) add_word(rand_word());
  endtask

  task automatic fill_smpl(input int unsigned loops);
    chunk_words.delete();
    for (int i = 0; i < 9; i++) add_word((i == 7) ? loops : rand_word());
    repeat (6 * loops) add_word(rand_word());
  endtask

  task automatic plan_random_chunk(input bit drain);
    logic [31:0] tag;
    logic [15:0] chans;
    case ($urandom_range(0, 9))
      0, 1: begin
        fill_cue($urandom_range(0, 3));
        plan_chunk(wcsp_pkg::TAG_CUE, struct_size(), drain);
      end
      2, 3: begin
        fill_smpl($urandom_range(0, 2));
        plan_chunk(wcsp_pkg::TAG_SMPL, struct_size(), drain);
      end
      4: begin
        // A well-formed format chunk, sometimes short (later checks never
        // reached) and sometimes long (extra bytes skipped).
        chans = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8));
        fill_fmt(wcsp_pkg::PCM_CODE, chans, $urandom, wcsp_pkg::BITS_REQUIRED);
        case ($urandom_range(0, 3))
          0: plan_chunk(wcsp_pkg::TAG_FMT, $urandom_range(0, 15), drain);
          1: plan_chunk(wcsp_pkg::TAG_FMT, 16 + $urandom_range(1, 8), drain);
          default: plan_chunk(wcsp_pkg::TAG_FMT, 16, drain);
        endcase
      end
      5: begin
        // Data after the first data chunk is skipped without output.
        chunk_words.delete();
        plan_chunk(wcsp_pkg::TAG_DATA, $urandom_range(0, 20), drain);
      end
      6: begin
        // Zero-size chunk of a known kind goes straight to the next tag.
        chunk_words.delete();
        case ($urandom_range(0, 3))
          0: tag = wcsp_pkg::TAG_FMT;
          1: tag = wcsp_pkg::TAG_DATA;
          2: tag = wcsp_pkg::TAG_CUE;
          default: tag = wcsp_pkg::TAG_SMPL;
        endcase
        plan_chunk(tag, 0, drain);
      end
      default: begin
        // Unknown chunk full of noise; a random tag that hits a checked kind is
        // nudged away from it.
        tag = $urandom;
        if (tag == wcsp_pkg::TAG_FMT || tag == wcsp_pkg::TAG_DATA) tag = tag ^ 32'h1;
        chunk_words.delete();
        plan_chunk(tag, $urandom_range(0, 30), drain);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: presents planned items at the falling edge and holds each one
  // until it is taken. In the gappy mode a random wait follows each item; the
  // mode flips now and then so that gap-free stretches occur as well.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    int         gap_left;
    bit         in_gappy;
    plan_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_plan.size() != 0 &&
                   !(byte_plan[0].drain && records_due.size() != 0)) begin
        nxt = byte_plan.pop_front();
        in_file_byte <= nxt.data;
        in_valid <= 1'b1;
        if ($urandom_range(0, 49) == 0) in_gappy = !in_gappy;
        gap_left = in_gappy ? $urandom_range(0, 10) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each taken record it stalls for a random time in its gappy
  // mode. Once, after HOLD_AT records, it makes its long hold while the sender
  // keeps offering items, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    int stall_left;
    bit out_gappy;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 49) == 0) out_gappy = !out_gappy;
        stall_left = out_gappy ? $urandom_range(0, 10) : 0;
        if (records_seen == HOLD_AT) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge it runs the model on an accepted item and
  // compares an accepted record with the oldest one still due.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    wav_rec_t due;
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (in_valid && !in_stall) parse_byte(in_file_byte);
      if (out_valid && !out_stall) begin
        records_seen <= records_seen + 1;
        if (records_due.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual kind %0d index %0d",
                   $time, out_record_kind, out_field_index);
          failures++;
        end else begin
          due = records_due.pop_front();
          check_field("record_kind", {29'd0, due.kind}, {29'd0, out_record_kind});
          check_field("field_index", {16'd0, due.index}, {16'd0, out_field_index});
          check_field("field_value", due.value, out_field_value);
          check_field("sample_value", {16'd0, due.sample}, {16'd0, out_sample_value});
          check_field("error_code", {29'd0, due.err}, {29'd0, out_error_code});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] bad_code;
    logic [15:0] bad_bits;

    // Directed opening: header, a long format chunk whose two extra bytes are
    // skipped, a zero-size chunk and a cue chunk that ends mid-word.
    plan_word(wcsp_pkg::TAG_RIFF, 1'b0);
    plan_word($urandom, 1'b0);
    plan_word(wcsp_pkg::TAG_WAVE, 1'b0);
    fill_fmt(wcsp_pkg::PCM_CODE, 16'd2, 32'd44100, wcsp_pkg::BITS_REQUIRED);
    plan_chunk(wcsp_pkg::TAG_FMT, 18, 1'b0);
    chunk_words.delete();
    plan_chunk(wcsp_pkg::TAG_CUE, 0, 1'b0);
    fill_cue(1);
    chunk_words[1] = 32'hFFFF_FFFF;
    plan_chunk(wcsp_pkg::TAG_CUE, 7, 1'b0);

    // The one data chunk that carries samples, odd-sized so that the last byte
    // yields nothing. Its length gives the long receiver hold room to back up.
    chunk_words.delete();
    add_word(32'h7FFF_8000);
    add_word(32'h0000_FFFF);
    repeat (60) add_word(rand_word());
    plan_chunk(wcsp_pkg::TAG_DATA, 2 * $urandom_range(50, 100) + 1, 1'b0);

    // Random chunks. The first of them waits until every record has drained.
    plan_random_chunk(1'b1);
    while (byte_plan.size() < 600) plan_random_chunk(1'b0);

    // The stream ends in one of the fatal errors that can follow a valid header,
    // and a few more bytes that must be ignored.
    case ($urandom_range(0, 2))
      0: begin
        bad_code = 16'($urandom);
        if (bad_code == wcsp_pkg::PCM_CODE) bad_code = 16'hFFFF;
        fill_fmt(bad_code, 16'd2, $urandom, wcsp_pkg::BITS_REQUIRED);
        plan_chunk(wcsp_pkg::TAG_FMT, 16, 1'b1);
      end
      1: begin
        bad_bits = 16'($urandom);
        if (bad_bits == wcsp_pkg::BITS_REQUIRED) bad_bits = 16'd24;
        fill_fmt(wcsp_pkg::PCM_CODE, 16'd2, $urandom, bad_bits);
        plan_chunk(wcsp_pkg::TAG_FMT, 16, 1'b1);
      end
      default: begin
        // A format with zero channels leaves the next data chunk without any.
        fill_fmt(wcsp_pkg::PCM_CODE, 16'd0, $urandom, wcsp_pkg::BITS_REQUIRED);
        plan_chunk(wcsp_pkg::TAG_FMT, 16, 1'b1);
        chunk_words.delete();
        plan_chunk(wcsp_pkg::TAG_DATA, 8, 1'b0);
      end
    endcase
    repeat (8) add_plan(8'($urandom), 1'b0);

    // Reset is asserted from the start and released at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last item to be taken, then for the records still due, and
    // then keep the clock running to catch anything extra the block might emit.
    while (byte_plan.size() != 0 || in_valid) @(posedge clk);
    for (int c = 0; c < 5000 && records_due.size() != 0; c++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (records_due.size() != 0) begin
      $display("%0t: missing records, expected %0d more, actual 0",
               $time, records_due.size());
      failures++;
    end

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
